@@ src/two_species_lattice_sweep_defines.svh @@
// Assertion macros shared by the two-species lattice sweep modules.
// No dependencies; taken in by `include where assertions are written.
`ifndef TWO_SPECIES_LATTICE_SWEEP_DEFINES_SVH
`define TWO_SPECIES_LATTICE_SWEEP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define TSLS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("two_species_lattice_sweep: assertion failed");

// Next-cycle implication, disabled during reset
`define TSLS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("two_species_lattice_sweep: assertion failed");

`endif

@@ src/tsls_pkg.sv @@
// Package for the two-species lattice sweep: field widths, reset values,
// register indexes and the types passed between front, queue and back.
// No dependencies.
package tsls_pkg;

   localparam int COUNT_W = 11;
   localparam int FRAC_W  = 16;
   localparam int SIZE_W  = 11;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [SIZE_W-1:0] RESET_LATTICE_SIZE = 11'd1024;
   localparam logic [FRAC_W-1:0] RESET_WIN_THRESH   = 16'd38550;
   localparam logic [FRAC_W-1:0] RESET_MUT_THRESH   = 16'd1311;

   // Register indexes (byte address divided by four)
   typedef enum logic [1:0] {
      REG_LATTICE_SIZE = 2'd0,
      REG_WIN_THRESH   = 2'd1,
      REG_MUT_THRESH   = 2'd2,
      REG_UNUSED       = 2'd3
   } reg_index_type;

   typedef enum logic {
      MODE_LOAD   = 1'b0,
      MODE_UPDATE = 1'b1
   } mode_type;

   typedef struct packed {
      logic [SIZE_W-1:0] lattice_size;
      logic [FRAC_W-1:0] win_thresh;
      logic [FRAC_W-1:0] mut_thresh;
   } cfg_type;

   // Per-transaction control, classified by the front end
   typedef struct packed {
      mode_type mode;
      logic     init_species;
      logic     phase;   // 0: odd sweep (left neighbour), 1: even sweep
      logic     last;
   } item_ctrl_type;

   typedef struct packed {
      logic [FRAC_W-1:0] u_select;
      logic [FRAC_W-1:0] u_mutate;
   } draws_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
      sat_inc = (c == COUNT_MAX) ? COUNT_MAX : c + 1'b1;
   endfunction

endpackage

@@ src/tsls_front.sv @@
// Front end of the lattice sweep: accepts transactions, tracks site and
// sweep phase, works out cell and neighbour addresses. Uses tsls_pkg.
module tsls_front
   import tsls_pkg::*;
#(
   parameter int MAX_SITES = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_mode,
   input  logic                          req_init_species,
   input  logic [FRAC_W-1:0]             req_u_select,
   input  logic [FRAC_W-1:0]             req_u_mutate,
   input  logic                          q_full,
   output logic                          q_push,
   output item_ctrl_type                 q_ctrl,
   output draws_type                     q_draws,
   output logic [$clog2(MAX_SITES)-1:0]  q_idx,
   output logic [$clog2(MAX_SITES)-1:0]  q_nb
);

   localparam int IW = $clog2(MAX_SITES);
   localparam int NW = (IW + 1 > SIZE_W) ? IW + 1 : SIZE_W;
   localparam logic [NW-1:0] N_MAX = NW'(MAX_SITES);
   localparam logic [NW-1:0] N_MIN = NW'(2);

   logic [IW-1:0] site_ff, site_in;
   logic          phase_ff, phase_in;
   logic [NW-1:0] size_ext, n_ring, n_less, site_plus;
   logic          last;
   logic          accept;

   // Clamp the ring size to the supported range
   always_comb begin
      size_ext = NW'(cfg.lattice_size);
      priority if (size_ext < N_MIN) begin
         n_ring = N_MIN;
      end else if (size_ext > N_MAX) begin
         n_ring = N_MAX;
      end else begin
         n_ring = size_ext;
      end
      n_less    = n_ring - 1'b1;
      site_plus = NW'(site_ff) + 1'b1;
      last      = (site_plus >= n_ring);
   end

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // Classify the transaction and pick the neighbour address
   always_comb begin
      q_push              = accept;
      q_ctrl.mode         = mode_type'(req_mode);
      q_ctrl.init_species = req_init_species;
      q_ctrl.phase        = phase_ff;
      q_ctrl.last         = last;
      q_draws.u_select    = req_u_select;
      q_draws.u_mutate    = req_u_mutate;
      q_idx               = site_ff;
      if (!phase_ff) begin
         q_nb = (site_ff == '0) ? n_less[IW-1:0] : site_ff - 1'b1;
      end else begin
         q_nb = last ? '0 : site_plus[IW-1:0];
      end
   end

   // Advance the site counter; flip or restart the phase at the end of a pass
   always_comb begin
      site_in  = site_ff;
      phase_in = phase_ff;
      if (accept) begin
         site_in = last ? '0 : site_plus[IW-1:0];
         if (last) begin
            phase_in = (mode_type'(req_mode) == MODE_UPDATE) ? ~phase_ff : 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         site_ff  <= '0;
         phase_ff <= 1'b0;
      end else begin
         site_ff  <= site_in;
         phase_ff <= phase_in;
      end
   end

endmodule

@@ src/tsls_queue.sv @@
// Short queue between front and back end of the lattice sweep.
// Uses tsls_pkg only for house consistency; assertions from the defines header.
`include "two_species_lattice_sweep_defines.svh"
module tsls_queue
   import tsls_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             not_empty,
   output logic             full
);

   localparam int DEPTH = 4;
   localparam int PW    = $clog2(DEPTH);
   localparam logic [PW:0] DEPTH_C = (PW + 1)'(DEPTH);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]      count_ff, count_in;

   assign dout      = store_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == DEPTH_C);

   // Track occupancy
   always_comb begin
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // Hold entry payload until popped
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= din;
      end
   end

   `TSLS_ASSERT_IMP(a_no_overflow, clock, reset, push, !full)
   `TSLS_ASSERT_IMP(a_no_underflow, clock, reset, pop, not_empty)
   `TSLS_ASSERT_NXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

@@ src/tsls_back.sv @@
// Back end of the lattice sweep: holds both lattices, reads cell and
// neighbour, resolves walls, keeps sweep counts and the result register.
// Uses tsls_pkg and the assertion macros in the defines header.
`include "two_species_lattice_sweep_defines.svh"
module tsls_back
   import tsls_pkg::*;
#(
   parameter int MAX_SITES = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  logic                          q_not_empty,
   output logic                          q_pop,
   input  item_ctrl_type                 q_ctrl,
   input  draws_type                     q_draws,
   input  logic [$clog2(MAX_SITES)-1:0]  q_idx,
   input  logic [$clog2(MAX_SITES)-1:0]  q_nb,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_new_species,
   output logic                          rsp_sweep_done,
   output logic [COUNT_W-1:0]            rsp_wall_count,
   output logic [COUNT_W-1:0]            rsp_wild_count,
   output logic                          rsp_absorbed
);

   localparam int IW = $clog2(MAX_SITES);
   localparam logic [IW-1:0] SITE_ONE = IW'(1);

   // Lattice stores, undefined until written
   logic even_mem [MAX_SITES];
   logic odd_mem  [MAX_SITES];

   // Execute stage
   logic          b_valid_ff;
   item_ctrl_type b_ctrl_ff;
   draws_type     b_draws_ff;
   logic [IW-1:0] b_idx_ff;
   logic          ev_c_ff, ev_o_ff, od_c_ff, od_o_ff;
   logic          even1_ff, odd1_ff;

   // Running counts
   logic [COUNT_W-1:0] walls_ff, walls_in, wild_ff, wild_in;

   // Result register
   logic               o_valid_ff;
   logic               o_species_ff, o_done_ff, o_abs_ff;
   logic [COUNT_W-1:0] o_walls_ff, o_wild_ff;

   logic               out_free, b_free, b_adv;
   logic               here_bit, nbr, wall, r_sel, wbit, wr_even, wr_odd, dst1, abs_bit;
   logic [COUNT_W-1:0] walls_upd, wild_upd;
   logic               b_hold, b_end, o_quiet;

   assign out_free = !o_valid_ff || !rsp_stall;
   assign b_adv    = b_valid_ff && out_free;
   assign b_free   = !b_valid_ff || out_free;
   assign q_pop    = q_not_empty && b_free;

   // Site result: load, or copy on agreement, draw on a wall, mutate wild
   always_comb begin
      here_bit  = b_ctrl_ff.phase ? od_c_ff : ev_c_ff;
      nbr       = b_ctrl_ff.phase ? od_o_ff : ev_o_ff;
      wall      = (here_bit != nbr);
      r_sel     = wall ? !(b_draws_ff.u_select < cfg.win_thresh) : here_bit;
      walls_upd = wall ? sat_inc(walls_ff) : walls_ff;
      wbit      = b_ctrl_ff.init_species;
      wr_even   = 1'b1;
      wr_odd    = 1'b0;
      wild_upd  = wild_ff;
      walls_in  = walls_ff;
      wild_in   = wild_ff;
      unique case (b_ctrl_ff.mode)
         MODE_LOAD: begin
            if (b_adv && b_ctrl_ff.last) begin
               walls_in = '0;
               wild_in  = '0;
            end
         end
         MODE_UPDATE: begin
            wbit     = r_sel | (b_draws_ff.u_mutate < cfg.mut_thresh);
            wild_upd = wbit ? wild_ff : sat_inc(wild_ff);
            wr_even  = b_ctrl_ff.phase;
            wr_odd   = !b_ctrl_ff.phase;
            if (b_adv) begin
               walls_in = b_ctrl_ff.last ? '0 : walls_upd;
               wild_in  = b_ctrl_ff.last ? '0 : wild_upd;
            end
         end
         default: ;
      endcase
      dst1    = (b_idx_ff == SITE_ONE) ? wbit : (b_ctrl_ff.phase ? even1_ff : odd1_ff);
      abs_bit = (walls_upd == '0) && dst1;
   end

   // Write the destination lattice and read the next cell, write-first
   always_ff @(posedge clock) begin
      if (b_adv && wr_even) begin
         even_mem[b_idx_ff] <= wbit;
      end
      if (b_adv && wr_odd) begin
         odd_mem[b_idx_ff] <= wbit;
      end
      if (q_pop) begin
         ev_c_ff <= (b_adv && wr_even && b_idx_ff == q_idx) ? wbit : even_mem[q_idx];
         ev_o_ff <= (b_adv && wr_even && b_idx_ff == q_nb)  ? wbit : even_mem[q_nb];
         od_c_ff <= (b_adv && wr_odd  && b_idx_ff == q_idx) ? wbit : odd_mem[q_idx];
         od_o_ff <= (b_adv && wr_odd  && b_idx_ff == q_nb)  ? wbit : odd_mem[q_nb];
      end
   end

   // Mirror site one of each lattice for the absorbed flag
   always_ff @(posedge clock) begin
      if (b_adv && b_idx_ff == SITE_ONE) begin
         if (wr_even) begin
            even1_ff <= wbit;
         end
         if (wr_odd) begin
            odd1_ff <= wbit;
         end
      end
   end

   // Execute stage payload
   always_ff @(posedge clock) begin
      if (q_pop) begin
         b_ctrl_ff  <= q_ctrl;
         b_draws_ff <= q_draws;
         b_idx_ff   <= q_idx;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (b_adv) begin
         o_species_ff <= wbit;
         o_done_ff    <= b_ctrl_ff.last;
         if (b_ctrl_ff.mode == MODE_UPDATE && b_ctrl_ff.last) begin
            o_walls_ff <= walls_upd;
            o_wild_ff  <= wild_upd;
            o_abs_ff   <= abs_bit;
         end else begin
            o_walls_ff <= '0;
            o_wild_ff  <= '0;
            o_abs_ff   <= 1'b0;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
         walls_ff   <= '0;
         wild_ff    <= '0;
      end else begin
         walls_ff <= walls_in;
         wild_ff  <= wild_in;
         if (b_free) begin
            b_valid_ff <= q_pop;
         end
         if (out_free) begin
            o_valid_ff <= b_adv;
         end
      end
   end

   assign rsp_valid       = o_valid_ff;
   assign rsp_new_species = o_species_ff;
   assign rsp_sweep_done  = o_done_ff;
   assign rsp_wall_count  = o_walls_ff;
   assign rsp_wild_count  = o_wild_ff;
   assign rsp_absorbed    = o_abs_ff;

   // Conditions watched by the checks below
   assign b_hold  = b_valid_ff && !out_free;
   assign b_end   = b_adv && b_ctrl_ff.last;
   assign o_quiet = o_valid_ff && !o_done_ff;

   `TSLS_ASSERT_NXT(a_read_hold, clock, reset, b_hold, $stable({ev_c_ff, ev_o_ff, od_c_ff, od_o_ff}))
   `TSLS_ASSERT_NXT(a_count_clear, clock, reset, b_end, walls_ff == '0 && wild_ff == '0)
   `TSLS_ASSERT_IMP(a_quiet_counts, clock, reset, o_quiet, (o_walls_ff | o_wild_ff) == '0 && !o_abs_ff)

endmodule

@@ src/two_species_lattice_sweep.sv @@
// Two-species lattice sweep: one site of a 1-D two-species ring automaton
// per transaction. The request channel carries mode (load or update), the
// species to load and two uniform draws; the response channel returns the
// species written, a sweep-done flag and, on the last site of an update
// sweep, the wall and wild counts and the absorbed flag.
// Throughput is one transaction per cycle while the response is not stalled: each site
// reads both lattices at two addresses and writes the destination lattice once.
// From request acceptance to a valid response a transaction passes through the queue
// entry, the lattice read and execute registers, and then the result register.
// The request stalls only when the four-entry queue is full; a stalled
// response holds its payload and the back end stops, the queue fills,
// and then the request side stalls.
// Reset clears the site counter, the phase (odd sweep next), the running
// counts and all valid flags and restores the register defaults. The
// lattices are not cleared: load every site before the first sweep.
// Registers sit at byte addresses 0 (lattice_size), 4 (win threshold) and
// 8 (mutation threshold); write them only while the block is idle.
module two_species_lattice_sweep
   import tsls_pkg::*;
#(
   parameter int MAX_SITES = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_mode,
   input  logic               req_init_species,
   input  logic [FRAC_W-1:0]  req_u_select,
   input  logic [FRAC_W-1:0]  req_u_mutate,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_new_species,
   output logic               rsp_sweep_done,
   output logic [COUNT_W-1:0] rsp_wall_count,
   output logic [COUNT_W-1:0] rsp_wild_count,
   output logic               rsp_absorbed
);

   localparam int IW    = $clog2(MAX_SITES);
   localparam int QW    = $bits(item_ctrl_type) + $bits(draws_type) + 2 * IW;

   cfg_type       cfg_ff;
   reg_index_type reg_sel;
   logic          wr_en;

   logic          q_push, q_pop, q_full, q_not_empty;
   item_ctrl_type f_ctrl, b_ctrl;
   draws_type     f_draws, b_draws;
   logic [IW-1:0] f_idx, f_nb, b_idx, b_nb;
   logic [QW-1:0] q_din, q_dout;

   // Register port
   assign pready  = 1'b1;
   assign reg_sel = reg_index_type'(paddr[3:2]);
   assign wr_en   = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lattice_size <= RESET_LATTICE_SIZE;
         cfg_ff.win_thresh   <= RESET_WIN_THRESH;
         cfg_ff.mut_thresh   <= RESET_MUT_THRESH;
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_LATTICE_SIZE: cfg_ff.lattice_size <= pwdata[SIZE_W-1:0];
            REG_WIN_THRESH:   cfg_ff.win_thresh   <= pwdata[FRAC_W-1:0];
            REG_MUT_THRESH:   cfg_ff.mut_thresh   <= pwdata[FRAC_W-1:0];
            REG_UNUSED:       ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_LATTICE_SIZE: prdata = 32'(cfg_ff.lattice_size);
         REG_WIN_THRESH:   prdata = 32'(cfg_ff.win_thresh);
         REG_MUT_THRESH:   prdata = 32'(cfg_ff.mut_thresh);
         REG_UNUSED:       prdata = '0;
      endcase
   end

   tsls_front #(
      .MAX_SITES (MAX_SITES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_init_species (req_init_species),
      .req_u_select     (req_u_select),
      .req_u_mutate     (req_u_mutate),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_ctrl           (f_ctrl),
      .q_draws          (f_draws),
      .q_idx            (f_idx),
      .q_nb             (f_nb)
   );

   assign q_din = {f_ctrl, f_draws, f_idx, f_nb};
   assign {b_ctrl, b_draws, b_idx, b_nb} = q_dout;

   tsls_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .din       (q_din),
      .pop       (q_pop),
      .dout      (q_dout),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   tsls_back #(
      .MAX_SITES (MAX_SITES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_not_empty     (q_not_empty),
      .q_pop           (q_pop),
      .q_ctrl          (b_ctrl),
      .q_draws         (b_draws),
      .q_idx           (b_idx),
      .q_nb            (b_nb),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_new_species (rsp_new_species),
      .rsp_sweep_done  (rsp_sweep_done),
      .rsp_wall_count  (rsp_wall_count),
      .rsp_wild_count  (rsp_wild_count),
      .rsp_absorbed    (rsp_absorbed)
   );

endmodule

@@ tb/sv/tb_two_species_lattice_sweep.sv @@
// Self-checking testbench for two_species_lattice_sweep: directed openers, random
// phases under several settings, and a site-by-site predictor of the ring automaton.
// Depends on tsls_pkg and the two_species_lattice_sweep top level only.
module tb_two_species_lattice_sweep;
   import tsls_pkg::*;

   localparam int SITES        = 1024;
   localparam int QUIET_LIMIT  = 3000;
   localparam int SMALL_ITEMS  = 600;
   localparam int WRAP_UPDATES = 120;
   localparam logic SPECIES_WILD   = 1'b0;
   localparam logic SPECIES_MUTANT = 1'b1;

   typedef enum int {FILL_RANDOM, FILL_MUTANT, FILL_WILD, FILL_BLOCKS} fill_style_type;

   typedef struct packed {
      mode_type          mode;
      logic              species;
      logic [FRAC_W-1:0] sel_draw;
      logic [FRAC_W-1:0] mut_draw;
   } site_req_type;

   typedef struct packed {
      logic               new_species;
      logic               sweep_done;
      logic [COUNT_W-1:0] walls;
      logic [COUNT_W-1:0] wilds;
      logic               absorbed;
   } site_outcome_type;

   logic               clock   = 1'b0;
   logic               reset   = 1'b1;
   logic               psel    = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite  = 1'b0;
   logic [3:0]         paddr   = '0;
   logic [31:0]        pwdata  = '0;
   logic [31:0]        prdata;
   logic               pready;
   logic               req_valid = 1'b0;
   logic               req_stall;
   site_req_type       on_wire   = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_new_species;
   logic               rsp_sweep_done;
   logic [COUNT_W-1:0] rsp_wall_count;
   logic [COUNT_W-1:0] rsp_wild_count;
   logic               rsp_absorbed;

   // Predictor state: register copies, both lattices, site counter and tallies
   logic [SIZE_W-1:0]  cfg_size = RESET_LATTICE_SIZE;
   logic [FRAC_W-1:0]  cfg_win  = RESET_WIN_THRESH;
   logic [FRAC_W-1:0]  cfg_mut  = RESET_MUT_THRESH;
   bit                 ring_even [SITES];
   bit                 ring_odd [SITES];
   int                 cur_site   = 0;
   bit                 even_next  = 1'b0;
   logic [COUNT_W-1:0] wall_tally = '0;
   logic [COUNT_W-1:0] wild_tally = '0;

   // Stimulus planning: which cells hold a written value, and where the pass stands
   bit                 even_written [SITES];
   bit                 odd_written [SITES];
   int                 plan_site       = 0;
   bit                 plan_even_next  = 1'b0;
   fill_style_type     fill            = FILL_RANDOM;
   int                 block_len       = 1;

   site_req_type       site_queue[$];
   site_outcome_type   pending_outcomes[$];
   int                 generated      = 0;
   int                 items_sent     = 0;
   int                 sweep_ends     = 0;
   int                 absorbed_seen  = 0;
   int                 mismatch_count = 0;
   int                 quiet_cycles   = 0;
   int                 send_idle_pct  = 0;
   int                 recv_stall_pct = 0;

   always #2 clock = ~clock;

   two_species_lattice_sweep dut (
      .clock            (clock),
      .reset            (reset),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (on_wire.mode),
      .req_init_species (on_wire.species),
      .req_u_select     (on_wire.sel_draw),
      .req_u_mutate     (on_wire.mut_draw),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_new_species  (rsp_new_species),
      .rsp_sweep_done   (rsp_sweep_done),
      .rsp_wall_count   (rsp_wall_count),
      .rsp_wild_count   (rsp_wild_count),
      .rsp_absorbed     (rsp_absorbed)
   );

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
   endtask

   // Ring size in effect: out-of-range register values clamp to 2..SITES
   function automatic int ring_sites();
      if (cfg_size < 2) return 2;
      if (cfg_size > SITES) return SITES;
      return int'(cfg_size);
   endfunction

   // Advance the lattice by one site and return what the block must answer
   function automatic site_outcome_type predict_site(input site_req_type rq);
      int n;
      int i;
      int nb;
      logic here;
      logic other;
      logic r;
      site_outcome_type o;
      n = ring_sites();
      i = cur_site;
      o = '0;
      o.sweep_done = (i + 1 >= n);
      if (rq.mode == MODE_LOAD) begin
         ring_even[i] = rq.species;
         o.new_species = rq.species;
         if (o.sweep_done) begin
            even_next = 1'b0;
            wall_tally = '0;
            wild_tally = '0;
         end
      end else begin
         // odd sweep looks left, even sweep looks right, both wrap
         if (!even_next) nb = (i == 0) ? n - 1 : i - 1;
         else nb = (i + 1 >= n) ? 0 : i + 1;
         here  = even_next ? ring_odd[i] : ring_even[i];
         other = even_next ? ring_odd[nb] : ring_even[nb];
         if (here == other) begin
            r = here;
         end else begin
            if (wall_tally != COUNT_MAX) wall_tally++;
            r = (rq.sel_draw < cfg_win) ? SPECIES_WILD : SPECIES_MUTANT;
         end
         if (r == SPECIES_WILD && rq.mut_draw < cfg_mut) r = SPECIES_MUTANT;
         if (r == SPECIES_WILD && wild_tally != COUNT_MAX) wild_tally++;
         if (even_next) ring_even[i] = r;
         else ring_odd[i] = r;
         o.new_species = r;
         if (o.sweep_done) begin
            o.walls = wall_tally;
            o.wilds = wild_tally;
            o.absorbed = (wall_tally == 0) &&
                         ((even_next ? ring_even[1] : ring_odd[1]) == SPECIES_MUTANT);
            wall_tally = '0;
            wild_tally = '0;
            even_next = !even_next;
         end
      end
      cur_site = o.sweep_done ? 0 : i + 1;
      return o;
   endfunction

   // Queue one site; an update that would read a never-written cell becomes a load
   function automatic void queue_site(input mode_type m, input logic sp,
                                      input logic [FRAC_W-1:0] us,
                                      input logic [FRAC_W-1:0] um);
      int n;
      int i;
      int nb;
      bit last;
      bit readable;
      site_req_type rq;
      n = ring_sites();
      i = plan_site;
      last = (i + 1 >= n);
      if (m == MODE_UPDATE) begin
         if (!plan_even_next) nb = (i == 0) ? n - 1 : i - 1;
         else nb = (i + 1 >= n) ? 0 : i + 1;
         if (plan_even_next)
            readable = odd_written[i] && odd_written[nb] &&
                       (!last || i == 1 || even_written[1]);
         else
            readable = even_written[i] && even_written[nb] &&
                       (!last || i == 1 || odd_written[1]);
         if (!readable) m = MODE_LOAD;
      end
      if (m == MODE_LOAD) begin
         even_written[i] = 1'b1;
         if (last) plan_even_next = 1'b0;
      end else begin
         if (plan_even_next) even_written[i] = 1'b1;
         else odd_written[i] = 1'b1;
         if (last) plan_even_next = !plan_even_next;
      end
      plan_site = last ? 0 : i + 1;
      rq.mode = m;
      rq.species = sp;
      rq.sel_draw = us;
      rq.mut_draw = um;
      site_queue.push_back(rq);
      generated++;
   endfunction

   function automatic logic pattern_species(input int site);
      case (fill)
         FILL_MUTANT: return SPECIES_MUTANT;
         FILL_WILD:   return SPECIES_WILD;
         FILL_BLOCKS: return ((site / block_len) % 2 == 1) ? SPECIES_MUTANT : SPECIES_WILD;
         default:     return 1'($urandom_range(1));
      endcase
   endfunction

   // Draws favour the extremes and the edges of the threshold
   function automatic logic [FRAC_W-1:0] pick_draw(input logic [FRAC_W-1:0] thr);
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return thr;
         3:       return thr - 1'b1;
         default: return FRAC_W'($urandom);
      endcase
   endfunction

   // Finish the pass in progress with loads, then load the whole ring afresh
   function automatic void reload_ring();
      int n;
      n = ring_sites();
      while (plan_site != 0)
         queue_site(MODE_LOAD, pattern_species(plan_site), FRAC_W'($urandom),
                    FRAC_W'($urandom));
      repeat (n) queue_site(MODE_LOAD, pattern_species(plan_site), FRAC_W'($urandom),
                            FRAC_W'($urandom));
   endfunction

   // Write a register through setup and access cycles, then read it back
   task automatic set_register(input reg_index_type idx, input logic [FRAC_W-1:0] value);
      logic [31:0] field;
      logic [31:0] word;
      field = (idx == REG_LATTICE_SIZE) ? {21'd0, value[SIZE_W-1:0]} : {16'd0, value};
      word  = (idx == REG_LATTICE_SIZE) ? (($urandom & ~32'h7FF) | field)
                                        : (($urandom & ~32'hFFFF) | field);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_LATTICE_SIZE: cfg_size = field[SIZE_W-1:0];
         REG_WIN_THRESH:   cfg_win  = field[FRAC_W-1:0];
         REG_MUT_THRESH:   cfg_mut  = field[FRAC_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      psel <= 1'b1;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== field)
         report_mismatch("register readback", longint'(prdata), longint'(field));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Wait until every item is sent and answered, then let the pipeline drain
   task automatic settle();
      @(negedge clock);
      while (site_queue.size() != 0 || req_valid || pending_outcomes.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Driver: predict each accepted transaction, then offer the next one
   always @(posedge clock) begin : drive_req
      site_req_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            pending_outcomes.push_back(predict_site(on_wire));
            items_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (site_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               it = site_queue.pop_front();
               on_wire   <= it;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted response against the oldest prediction
   always @(posedge clock) begin : watch_rsp
      site_outcome_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_outcomes.size() == 0) begin
               report_mismatch("response with nothing outstanding", 1, 0);
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_new_species !== want.new_species)
                  report_mismatch("new_species", longint'(rsp_new_species),
                                  longint'(want.new_species));
               if (rsp_sweep_done !== want.sweep_done)
                  report_mismatch("sweep_done", longint'(rsp_sweep_done),
                                  longint'(want.sweep_done));
               if (rsp_wall_count !== want.walls)
                  report_mismatch("wall_count", longint'(rsp_wall_count),
                                  longint'(want.walls));
               if (rsp_wild_count !== want.wilds)
                  report_mismatch("wild_count", longint'(rsp_wild_count),
                                  longint'(want.wilds));
               if (rsp_absorbed !== want.absorbed)
                  report_mismatch("absorbed", longint'(rsp_absorbed),
                                  longint'(want.absorbed));
               if (want.sweep_done) sweep_ends++;
               if (want.absorbed) absorbed_seen++;
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Watchdog: give up when no transaction moves for too long
   always @(posedge clock) begin : watchdog
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("two_species_lattice_sweep verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      int n;
      int count;
      int phase_no;
      int pick;
      logic [FRAC_W-1:0] sz;
      logic [FRAC_W-1:0] win;
      logic [FRAC_W-1:0] mut;
      mode_type m;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: four-site ring, wild wins a wall unless the draw is all ones, mutation off
      set_register(REG_LATTICE_SIZE, 16'd4);
      set_register(REG_WIN_THRESH, 16'hFFFF);
      set_register(REG_MUT_THRESH, 16'h0000);
      queue_site(MODE_LOAD, SPECIES_MUTANT, 16'hFFFF, 16'h0000);
      queue_site(MODE_LOAD, SPECIES_WILD, 16'h0000, 16'hFFFF);
      queue_site(MODE_LOAD, SPECIES_WILD, 16'h0000, 16'h0000);
      queue_site(MODE_LOAD, SPECIES_MUTANT, 16'hFFFF, 16'hFFFF);
      queue_site(MODE_UPDATE, SPECIES_WILD, 16'h0000, 16'h0000);
      queue_site(MODE_UPDATE, SPECIES_MUTANT, 16'hFFFF, 16'h0000);
      queue_site(MODE_UPDATE, SPECIES_WILD, 16'h0000, 16'hFFFF);
      queue_site(MODE_UPDATE, SPECIES_MUTANT, 16'h0000, 16'h0000);
      queue_site(MODE_UPDATE, SPECIES_WILD, 16'hFFFF, 16'hFFFF);
      queue_site(MODE_UPDATE, SPECIES_MUTANT, 16'h0000, 16'h0000);
      queue_site(MODE_UPDATE, SPECIES_WILD, 16'hFFFF, 16'h0000);
      queue_site(MODE_UPDATE, SPECIES_MUTANT, 16'h0000, 16'hFFFF);
      settle();

      // Directed: size below range clamps to 2; all-mutant ring is absorbed,
      // then a load finishes an even sweep
      set_register(REG_LATTICE_SIZE, 16'd0);
      set_register(REG_WIN_THRESH, 16'h0000);
      set_register(REG_MUT_THRESH, 16'hFFFF);
      queue_site(MODE_LOAD, SPECIES_MUTANT, 16'h1234, 16'h4321);
      queue_site(MODE_LOAD, SPECIES_MUTANT, 16'hEDCB, 16'hBCDE);
      queue_site(MODE_UPDATE, SPECIES_WILD, 16'h8000, 16'hFFFE);
      queue_site(MODE_UPDATE, SPECIES_WILD, 16'h7FFF, 16'hFFFE);
      queue_site(MODE_UPDATE, SPECIES_MUTANT, 16'h0000, 16'hFFFF);
      queue_site(MODE_LOAD, SPECIES_WILD, 16'hFFFF, 16'h0000);
      settle();

      // Directed: size one clamps to 2; mutation threshold of one
      set_register(REG_LATTICE_SIZE, 16'd1);
      set_register(REG_WIN_THRESH, 16'h8000);
      set_register(REG_MUT_THRESH, 16'h0001);
      queue_site(MODE_LOAD, SPECIES_WILD, 16'h5555, 16'hAAAA);
      queue_site(MODE_LOAD, SPECIES_WILD, 16'hAAAA, 16'h5555);
      queue_site(MODE_UPDATE, SPECIES_MUTANT, 16'h0000, 16'h0000);
      queue_site(MODE_UPDATE, SPECIES_MUTANT, 16'hFFFF, 16'h0001);

      // Random phases on small rings, cycling through the idling modes
      phase_no = 0;
      while (generated < SMALL_ITEMS + 22 || phase_no < 8) begin
         settle();
         case (phase_no % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
            default: begin send_idle_pct = 8; recv_stall_pct = 8; end
         endcase
         pick = $urandom_range(99);
         if (pick < 8) sz = FRAC_W'($urandom_range(1));
         else if (pick < 80) sz = FRAC_W'($urandom_range(2, 24));
         else sz = FRAC_W'($urandom_range(25, 100));
         case ($urandom_range(5))
            0: win = '0;
            1: win = '1;
            2: win = RESET_WIN_THRESH;
            3: win = 16'h8000;
            default: win = FRAC_W'($urandom);
         endcase
         case ($urandom_range(5))
            0: mut = '0;
            1: mut = '1;
            2: mut = RESET_MUT_THRESH;
            3: mut = FRAC_W'($urandom_range(1, 4096));
            default: mut = FRAC_W'($urandom);
         endcase
         set_register(REG_LATTICE_SIZE, sz);
         set_register(REG_WIN_THRESH, win);
         set_register(REG_MUT_THRESH, mut);
         fill = fill_style_type'($urandom_range(3));
         block_len = $urandom_range(1, 6);
         n = ring_sites();
         if ($urandom_range(1) == 1) reload_ring();
         count = n * $urandom_range(2, 4) + $urandom_range(0, n);
         if (count > 240) count = 240;
         // mostly sweeps; a few loads land mid-sweep
         repeat (count) begin
            m = ($urandom_range(99) < 6) ? MODE_LOAD : MODE_UPDATE;
            queue_site(m, pattern_species(plan_site), pick_draw(cfg_win), pick_draw(cfg_mut));
         end
         phase_no++;
      end

      // One full-size ring: register at or above the top, reload, then
      // updates from site zero across the wrap to the top site
      settle();
      send_idle_pct = 8;
      recv_stall_pct = 8;
      case ($urandom_range(2))
         0: sz = FRAC_W'(SITES);
         1: sz = 16'd2047;
         default: sz = FRAC_W'($urandom_range(SITES + 1, 2046));
      endcase
      set_register(REG_LATTICE_SIZE, sz);
      set_register(REG_WIN_THRESH, FRAC_W'($urandom));
      set_register(REG_MUT_THRESH, FRAC_W'($urandom_range(0, 8192)));
      fill = FILL_BLOCKS;
      block_len = $urandom_range(8, 64);
      reload_ring();
      repeat (WRAP_UPDATES)
         queue_site(MODE_UPDATE, 1'($urandom_range(1)), pick_draw(cfg_win),
                    pick_draw(cfg_mut));

      settle();
      repeat (8) @(posedge clock);
      if (pending_outcomes.size() != 0)
         report_mismatch("responses never returned", pending_outcomes.size(), 0);
      $display("Sent %0d site transactions over %0d random settings plus directed rings;",
               items_sent, phase_no + 1);
      $display("%0d sweep or load ends seen, %0d of them absorbed.", sweep_ends, absorbed_seen);
      if (mismatch_count == 0)
         $display("two_species_lattice_sweep verification clean");
      else
         $display("two_species_lattice_sweep verification failed");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+src
src/tsls_pkg.sv
src/tsls_front.sv
src/tsls_queue.sv
src/tsls_back.sv
src/two_species_lattice_sweep.sv
tb/sv/tb_two_species_lattice_sweep.sv
